// ===== rtl/core/quaternion_arithmetic_unit_macros.svh =====
// Assertion macros for the quaternion arithmetic unit.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define QAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/qau_pkg.sv =====
// Shared types, opcodes and the saturating word clip of the quaternion unit.
// No dependencies.
package qau_pkg;

    localparam int WORD_BITS         = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ACC_BITS          = 2 * WORD_BITS + 2;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;
    typedef logic [2:0]                  opcode_t;

    localparam opcode_t OP_ADD  = 3'd0;
    localparam opcode_t OP_SUB  = 3'd1;
    localparam opcode_t OP_MUL  = 3'd2;
    localparam opcode_t OP_CONJ = 3'd3;
    localparam opcode_t OP_ROT  = 3'd4;

    typedef struct packed {
        logic  flag;
        word_t word;
    } sat_word_t;

    typedef struct packed {
        word_t s;
        word_t x;
        word_t y;
        word_t z;
    } quat_t;

    function automatic sat_word_t sat_word(acc_t v);
        word_t     wmax;
        word_t     wmin;
        sat_word_t r;
        wmax = {1'b0, {(WORD_BITS-1){1'b1}}};
        wmin = {1'b1, {(WORD_BITS-1){1'b0}}};
        if (v > acc_t'(wmax)) begin
            r.word = wmax;
            r.flag = 1'b1;
        end else if (v < acc_t'(wmin)) begin
            r.word = wmin;
            r.flag = 1'b1;
        end else begin
            r.word = v[WORD_BITS-1:0];
            r.flag = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/qau_dot4.sv =====
// Four-term signed dot product lane: multiply, exact sum, round and clip.
// Three register stages sharing one enable. Depends on qau_pkg.
module qau_dot4 import qau_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic             aclk,
    input  logic             en,
    input  word_t [3:0]      x,
    input  word_t [3:0]      y,
    input  logic [3:0]       neg,
    output sat_word_t        res
);

    typedef logic signed [2*WORD_BITS-1:0] prod_t;

    prod_t      prod_reg [4];
    logic [3:0] neg_reg;
    acc_t       sum_reg;
    acc_t       sum_next;
    acc_t       rnd_sum;
    acc_t       shifted;
    sat_word_t  res_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= $signed(x[i]) * $signed(y[i]);
            end
            neg_reg <= neg;
        end
    end

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < 4; i++) begin
            if (neg_reg[i]) begin
                sum_next = sum_next - acc_t'(prod_reg[i]);
            end else begin
                sum_next = sum_next + acc_t'(prod_reg[i]);
            end
        end
    end

    // round half up, then arithmetic shift down to the word's fraction
    always_comb begin
        rnd_sum = sum_reg + (acc_t'(1) <<< (FRACTION_BITS - 1));
        shifted = rnd_sum >>> FRACTION_BITS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            res_reg <= sat_word(shifted);
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/quaternion_arithmetic_unit.sv =====
// Channel | ports                         | contents
// input   | s_tvalid s_tready s_tdata/user | opcode; quaternions a and b
// result  | m_tvalid m_tready m_tdata/user | result quaternion; saturated flag
// One request accepted per cycle unless the pipeline holds. The rotate path sets the
// depth: two chained product rounds of three stages each (multiply, sum,
// round and clip) between an input and an output register.
// Reset clears only the valid bits. The whole pipeline holds while the
// output register is full and not taken.
// Top level of the quaternion arithmetic unit. Depends on qau_pkg,
// qau_dot4 and quaternion_arithmetic_unit_macros.svh.
`include "quaternion_arithmetic_unit_macros.svh"

module quaternion_arithmetic_unit import qau_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // a_scalar, a_x, a_y, a_z, b_scalar, b_x, b_y, b_z
    input  logic [8*WORD_BITS-1:0] s_tdata,
    // opcode
    input  logic [2:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // r_scalar, r_x, r_y, r_z
    output logic [4*WORD_BITS-1:0] m_tdata,
    // saturated
    output logic [0:0]             m_tuser
);

    typedef struct packed {
        opcode_t op;
        quat_t   a;
        quat_t   dir;
        logic    dflag;
    } sa_t;

    typedef struct packed {
        opcode_t op;
        quat_t   res;
        logic    flag;
    } sb_t;

    logic                   en;
    logic [7:0]             v_reg;
    opcode_t                in_op_reg;
    quat_t                  in_a_reg;
    quat_t                  in_b_reg;
    quat_t                  dir_next;
    logic                   dflag_next;
    sat_word_t              d0, d1, d2, d3;
    word_t                  bs_m;
    word_t [3:0]            r1_x [4];
    word_t [3:0]            r1_y [4];
    word_t [3:0]            r2_x [3];
    word_t [3:0]            r2_y [3];
    sat_word_t              r1 [4];
    sat_word_t              r2 [3];
    sa_t                    sa_reg [1:3];
    sb_t                    sb_reg [4:6];
    sb_t                    sb_next;
    logic [4*WORD_BITS-1:0] m_tdata_reg;
    logic [4*WORD_BITS-1:0] m_tdata_next;
    logic                   m_tuser_reg;
    logic                   m_tuser_next;

    assign en       = !v_reg[7] || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[7];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_op_reg  <= s_tuser;
            in_a_reg.s <= s_tdata[1*WORD_BITS-1:0*WORD_BITS];
            in_a_reg.x <= s_tdata[2*WORD_BITS-1:1*WORD_BITS];
            in_a_reg.y <= s_tdata[3*WORD_BITS-1:2*WORD_BITS];
            in_a_reg.z <= s_tdata[4*WORD_BITS-1:3*WORD_BITS];
            in_b_reg.s <= s_tdata[5*WORD_BITS-1:4*WORD_BITS];
            in_b_reg.x <= s_tdata[6*WORD_BITS-1:5*WORD_BITS];
            in_b_reg.y <= s_tdata[7*WORD_BITS-1:6*WORD_BITS];
            in_b_reg.z <= s_tdata[8*WORD_BITS-1:7*WORD_BITS];
        end
    end

    // add, subtract and conjugate need no products
    always_comb begin
        d0 = '0;
        d1 = '0;
        d2 = '0;
        d3 = '0;
        unique case (in_op_reg)
            OP_ADD: begin
                d0 = sat_word(acc_t'($signed(in_a_reg.s)) + acc_t'($signed(in_b_reg.s)));
                d1 = sat_word(acc_t'($signed(in_a_reg.x)) + acc_t'($signed(in_b_reg.x)));
                d2 = sat_word(acc_t'($signed(in_a_reg.y)) + acc_t'($signed(in_b_reg.y)));
                d3 = sat_word(acc_t'($signed(in_a_reg.z)) + acc_t'($signed(in_b_reg.z)));
            end
            OP_SUB: begin
                d0 = sat_word(acc_t'($signed(in_a_reg.s)) - acc_t'($signed(in_b_reg.s)));
                d1 = sat_word(acc_t'($signed(in_a_reg.x)) - acc_t'($signed(in_b_reg.x)));
                d2 = sat_word(acc_t'($signed(in_a_reg.y)) - acc_t'($signed(in_b_reg.y)));
                d3 = sat_word(acc_t'($signed(in_a_reg.z)) - acc_t'($signed(in_b_reg.z)));
            end
            OP_CONJ: begin
                d0.word = in_a_reg.s;
                d1 = sat_word(-acc_t'($signed(in_a_reg.x)));
                d2 = sat_word(-acc_t'($signed(in_a_reg.y)));
                d3 = sat_word(-acc_t'($signed(in_a_reg.z)));
            end
            default: begin
            end
        endcase
        dir_next   = '{s: d0.word, x: d1.word, y: d2.word, z: d3.word};
        dflag_next = d0.flag | d1.flag | d2.flag | d3.flag;
    end

    // first round: Hamilton product a*b; rotate is the same with b scalar 0
    always_comb begin
        bs_m = (in_op_reg == OP_ROT) ? '0 : in_b_reg.s;
        r1_x[0] = {in_a_reg.z, in_a_reg.y, in_a_reg.x, in_a_reg.s};
        r1_y[0] = {in_b_reg.z, in_b_reg.y, in_b_reg.x, bs_m};
        r1_x[1] = {in_a_reg.z, in_a_reg.y, bs_m, in_a_reg.s};
        r1_y[1] = {in_b_reg.y, in_b_reg.z, in_a_reg.x, in_b_reg.x};
        r1_x[2] = {in_a_reg.x, in_a_reg.z, bs_m, in_a_reg.s};
        r1_y[2] = {in_b_reg.z, in_b_reg.x, in_a_reg.y, in_b_reg.y};
        r1_x[3] = {in_a_reg.y, in_a_reg.x, bs_m, in_a_reg.s};
        r1_y[3] = {in_b_reg.x, in_b_reg.y, in_a_reg.z, in_b_reg.z};
    end

    for (genvar i = 0; i < 4; i++) begin : g_r1
        qau_dot4 #(.FRACTION_BITS(FRACTION_BITS)) u_dot (
            .aclk (aclk),
            .en   (en),
            .x    (r1_x[i]),
            .y    (r1_y[i]),
            .neg  ((i == 0) ? 4'b1110 : 4'b1000),
            .res  (r1[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg[1] <= '{op: in_op_reg, a: in_a_reg, dir: dir_next, dflag: dflag_next};
            sa_reg[2] <= sa_reg[1];
            sa_reg[3] <= sa_reg[2];
        end
    end

    // second round (rotate): -w*a.vec + a.s*q + a.vec x q
    always_comb begin
        r2_x[0] = {sa_reg[3].a.z, sa_reg[3].a.y, sa_reg[3].a.s, r1[0].word};
        r2_y[0] = {r1[2].word, r1[3].word, r1[1].word, sa_reg[3].a.x};
        r2_x[1] = {sa_reg[3].a.x, sa_reg[3].a.z, sa_reg[3].a.s, r1[0].word};
        r2_y[1] = {r1[3].word, r1[1].word, r1[2].word, sa_reg[3].a.y};
        r2_x[2] = {sa_reg[3].a.y, sa_reg[3].a.x, sa_reg[3].a.s, r1[0].word};
        r2_y[2] = {r1[1].word, r1[2].word, r1[3].word, sa_reg[3].a.z};
    end

    for (genvar i = 0; i < 3; i++) begin : g_r2
        qau_dot4 #(.FRACTION_BITS(FRACTION_BITS)) u_dot (
            .aclk (aclk),
            .en   (en),
            .x    (r2_x[i]),
            .y    (r2_y[i]),
            .neg  (4'b1001),
            .res  (r2[i])
        );
    end

    always_comb begin
        sb_next.op = sa_reg[3].op;
        if (sa_reg[3].op == OP_MUL) begin
            sb_next.res  = '{s: r1[0].word, x: r1[1].word, y: r1[2].word, z: r1[3].word};
            sb_next.flag = r1[0].flag | r1[1].flag | r1[2].flag | r1[3].flag;
        end else if (sa_reg[3].op == OP_ROT) begin
            sb_next.res  = '0;
            sb_next.flag = r1[0].flag | r1[1].flag | r1[2].flag | r1[3].flag;
        end else begin
            sb_next.res  = sa_reg[3].dir;
            sb_next.flag = sa_reg[3].dflag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[4] <= sb_next;
            sb_reg[5] <= sb_reg[4];
            sb_reg[6] <= sb_reg[5];
        end
    end

    always_comb begin
        if (sb_reg[6].op == OP_ROT) begin
            m_tdata_next = {r2[2].word, r2[1].word, r2[0].word, word_t'(0)};
            m_tuser_next = sb_reg[6].flag | r2[0].flag | r2[1].flag | r2[2].flag;
        end else begin
            m_tdata_next = {sb_reg[6].res.z, sb_reg[6].res.y, sb_reg[6].res.x,
                            sb_reg[6].res.s};
            m_tuser_next = sb_reg[6].flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    `QAU_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, v_reg[0], "accepted request lost")
    `QAU_ASSERT_NXT(a_stall_holds, !en, $stable(v_reg) && $stable(m_tdata_reg), "pipeline moved in stall")
    `QAU_ASSERT_NXT(a_rot_scalar, en && v_reg[6] && sb_reg[6].op == OP_ROT, m_tdata[WORD_BITS-1:0] == '0, "rotate scalar not zero")
    `QAU_ASSERT_IMP(a_undef_zero, v_reg[3] && sa_reg[3].op > OP_ROT, sb_next.res == '0 && !sb_next.flag, "undefined opcode result not clear")

endmodule
